// File: src/lrpg_pkg.sv
`default_nettype none
package lrpg_pkg;

	localparam int unsigned IDX_W = 6;

	localparam logic [2:0] OP_IDLE     = 3'd0;
	localparam logic [2:0] OP_LISTEN   = 3'd1;
	localparam logic [2:0] OP_THINK    = 3'd2;
	localparam logic [2:0] OP_SPEAK    = 3'd3;
	localparam logic [2:0] OP_ERROR    = 3'd4;
	localparam logic [2:0] OP_UPDATE   = 3'd5;
	localparam logic [2:0] OP_MUSIC    = 3'd6;
	localparam logic [2:0] OP_FOLLOWUP = 3'd7;

	typedef enum logic [2:0] {
		MODE_DARK,
		MODE_RAINBOW,
		MODE_LISTEN,
		MODE_THINK,
		MODE_SPEAK,
		MODE_ERROR,
		MODE_UPDATE,
		MODE_FOLLOW
	} mode_t;

	typedef struct packed {
		logic [31:0] time_ms;
		logic [2:0]  operation;
		logic [7:0]  level;
	} in_word_t;

	typedef struct packed {
		logic [IDX_W-1:0] pixel_index;
		logic [7:0]       red;
		logic [7:0]       green;
		logic [7:0]       blue;
		logic             last;
	} out_word_t;

	typedef struct packed {
		logic [7:0] r;
		logic [7:0] g;
		logic [7:0] b;
	} rgb_t;

	typedef struct packed {
		mode_t            mode;
		logic [IDX_W-1:0] head;
		logic [15:0]      base;
		logic [7:0]       rv;
		logic [IDX_W:0]   lit;
		logic [7:0]       sv;
		logic             err_on;
	} frame_t;

	typedef struct packed {
		frame_t           frame;
		logic [IDX_W-1:0] idx;
		logic             last;
	} pix_req_t;

	localparam int unsigned THINK_STEP_MS  = 70;
	localparam int unsigned FOLLOW_STEP_MS = 110;
	localparam int unsigned BLINK_MS       = 180;

	localparam int unsigned HEAD_SH = 20;
	localparam logic [14:0] THINK_MAG =
		15'(((64'd1 << HEAD_SH) + 64'(THINK_STEP_MS) - 64'd1) / 64'(THINK_STEP_MS));
	localparam logic [14:0] FOLLOW_MAG =
		15'(((64'd1 << HEAD_SH) + 64'(FOLLOW_STEP_MS) - 64'd1) / 64'(FOLLOW_STEP_MS));

	localparam logic [16:0] DIV255_MAG = 17'd65794;
	localparam int unsigned DIV255_SH  = 24;

	localparam logic [7:0] RAINBOW_PEAK = 8'd160;
	localparam logic [7:0] SPEAK_PEAK   = 8'd155;
	localparam logic [5:0] SPEED_BASE   = 6'd6;
	localparam logic [7:0] LISTEN_FULL  = 8'd170;

	localparam rgb_t RGB_OFF     = '{r: 8'd0,   g: 8'd0,  b: 8'd0};
	localparam rgb_t RGB_ERROR   = '{r: 8'd130, g: 8'd0,  b: 8'd0};
	localparam rgb_t RGB_DOT     = '{r: 8'd150, g: 8'd68, b: 8'd0};
	localparam rgb_t RGB_DOT_BG  = '{r: 8'd14,  g: 8'd6,  b: 8'd0};

	// Residue of a 32-bit value, folded byte by byte with the byte weights mod M.
	function automatic logic [22:0] fold_mod(input logic [31:0] t, input logic [12:0] c1,
		input logic [12:0] c2, input logic [12:0] c3);
		return 23'(t[7:0]) + 23'(t[15:8]) * 23'(c1) + 23'(t[23:16]) * 23'(c2)
			+ 23'(t[31:24]) * 23'(c3);
	endfunction

	// Exact x / 255 for x below 66052.
	function automatic logic [7:0] div255(input logic [15:0] x);
		logic [32:0] p;
		p = 33'(x) * 33'(DIV255_MAG);
		return p[DIV255_SH+7:DIV255_SH];
	endfunction

endpackage
`default_nettype wire

// File: src/led_ring_pattern_generator.sv
// LED ring frame generator.
// A word on the input channel (in_valid/in_ready, in_word) is one frame request:
// time in milliseconds, display mode and audio level. For each request the block
// sends RING_LEDS words on the output channel (out_valid/out_ready, out_word),
// one per LED in index order, with last set on the final LED.
// The single configuration bit is written through cfg_we/cfg_wdata and selects
// whether idle mode shows the level-driven rainbow or stays dark.
// From an accepted request, the first pixel of a frame passes eleven registers:
// five frame setup stages, the frame register and five pixel stages; the
// accepting edge loads the first of them.
// Throughput: one pixel per cycle while out_ready stays high; the frame
// sequencer steps through the LEDs one per cycle unless the pixel stages are
// full. Requests queue in the setup stages while a frame is being sent.
// Reset clears all valid bits, the LED counter and the configuration bit.
// When the receiver holds out_ready low, the output word stays put, the pixel
// stages fill up and stop, and in_ready drops once every stage holds a word.
`default_nettype none
module led_ring_pattern_generator
	import lrpg_pkg::*;
#(
	parameter int unsigned RING_LEDS = 12
) (
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire logic      cfg_we,
	input  wire logic      cfg_wdata,
	input  wire logic      in_valid,
	output logic           in_ready,
	input  wire in_word_t  in_word,
	output logic           out_valid,
	input  wire logic      out_ready,
	output out_word_t      out_word
);

	localparam int unsigned M70  = THINK_STEP_MS * RING_LEDS;
	localparam int unsigned M110 = FOLLOW_STEP_MS * RING_LEDS;
	localparam int unsigned M360 = 2 * BLINK_MS;
	localparam int unsigned QSH  = 36;

	localparam logic [12:0] F70_1  = 13'((64'd1 << 8) % 64'(M70));
	localparam logic [12:0] F70_2  = 13'((64'd1 << 16) % 64'(M70));
	localparam logic [12:0] F70_3  = 13'((64'd1 << 24) % 64'(M70));
	localparam logic [12:0] F110_1 = 13'((64'd1 << 8) % 64'(M110));
	localparam logic [12:0] F110_2 = 13'((64'd1 << 16) % 64'(M110));
	localparam logic [12:0] F110_3 = 13'((64'd1 << 24) % 64'(M110));
	localparam logic [12:0] F360_1 = 13'((64'd1 << 8) % 64'(M360));
	localparam logic [12:0] F360_2 = 13'((64'd1 << 16) % 64'(M360));
	localparam logic [12:0] F360_3 = 13'((64'd1 << 24) % 64'(M360));

	localparam logic [29:0] Q70_MAG  = 30'(((64'd1 << QSH) + 64'(M70) - 64'd1) / 64'(M70));
	localparam logic [29:0] Q110_MAG = 30'(((64'd1 << QSH) + 64'(M110) - 64'd1) / 64'(M110));
	localparam logic [29:0] Q360_MAG = 30'(((64'd1 << QSH) + 64'(M360) - 64'd1) / 64'(M360));

	localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(RING_LEDS - 1);

	logic idle_rb_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idle_rb_q <= 1'b0;
		end else if (cfg_we) begin
			idle_rb_q <= cfg_wdata;
		end
	end

	logic ld_s1, ld_s2, ld_s3, ld_s4, ld_s5, fr_ld;
	logic vld_s1, vld_s2, vld_s3, vld_s4, vld_s5;
	logic fr_vld_q;
	logic [IDX_W-1:0] cnt_q;
	logic pix_ready;
	logic cnt_last;

	assign cnt_last = (cnt_q == LAST_IDX);
	assign fr_ld    = !fr_vld_q || (pix_ready && cnt_last);
	assign ld_s5    = !vld_s5 || fr_ld;
	assign ld_s4    = !vld_s4 || ld_s5;
	assign ld_s3    = !vld_s3 || ld_s4;
	assign ld_s2    = !vld_s2 || ld_s3;
	assign ld_s1    = !vld_s1 || ld_s2;
	assign in_ready = ld_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1   <= 1'b0;
			vld_s2   <= 1'b0;
			vld_s3   <= 1'b0;
			vld_s4   <= 1'b0;
			vld_s5   <= 1'b0;
			fr_vld_q <= 1'b0;
			cnt_q    <= '0;
		end else begin
			if (ld_s1) vld_s1 <= in_valid;
			if (ld_s2) vld_s2 <= vld_s1;
			if (ld_s3) vld_s3 <= vld_s2;
			if (ld_s4) vld_s4 <= vld_s3;
			if (ld_s5) vld_s5 <= vld_s4;
			if (fr_ld) begin
				fr_vld_q <= vld_s5;
				cnt_q    <= '0;
			end else if (fr_vld_q && pix_ready) begin
				cnt_q <= cnt_q + IDX_W'(1);
			end
		end
	end

	// Stage 1: request and resolved mode.
	logic [31:0] t_s1;
	logic [7:0]  lvl_s1;
	mode_t       mode_s1;
	mode_t       mode_in;

	always_comb begin
		unique case (in_word.operation)
			OP_IDLE:     mode_in = idle_rb_q ? MODE_RAINBOW : MODE_DARK;
			OP_LISTEN:   mode_in = MODE_LISTEN;
			OP_THINK:    mode_in = MODE_THINK;
			OP_SPEAK:    mode_in = MODE_SPEAK;
			OP_ERROR:    mode_in = MODE_ERROR;
			OP_UPDATE:   mode_in = MODE_UPDATE;
			OP_MUSIC:    mode_in = MODE_RAINBOW;
			OP_FOLLOWUP: mode_in = MODE_FOLLOW;
		endcase
	end

	always_ff @(posedge clk) begin
		if (ld_s1) begin
			t_s1    <= in_word.time_ms;
			lvl_s1  <= in_word.level;
			mode_s1 <= mode_in;
		end
	end

	// Stage 2: time folded into small residues, level products, rainbow base.
	mode_t       mode_s2;
	logic [22:0] x70_s2, x110_s2, x360_s2;
	logic [15:0] p160_s2, plit_s2, p155_s2;
	logic [15:0] base_s2;
	logic [21:0] base_prod;

	assign base_prod = 22'(t_s1[15:0]) * 22'(6'(lvl_s1[7:3]) + SPEED_BASE);

	always_ff @(posedge clk) begin
		if (ld_s2) begin
			mode_s2  <= mode_s1;
			x70_s2   <= fold_mod(t_s1, F70_1, F70_2, F70_3);
			x110_s2  <= fold_mod(t_s1, F110_1, F110_2, F110_3);
			x360_s2  <= fold_mod(t_s1, F360_1, F360_2, F360_3);
			p160_s2  <= 16'(lvl_s1) * 16'(RAINBOW_PEAK);
			plit_s2  <= 16'(lvl_s1) * 16'(RING_LEDS) + 16'd127;
			p155_s2  <= 16'(lvl_s1) * 16'(SPEAK_PEAK);
			base_s2  <= base_prod[15:0];
		end
	end

	// Stage 3: quotients by reciprocal multiplication.
	mode_t          mode_s3;
	logic [22:0]    x70_s3, x110_s3, x360_s3;
	logic [15:0]    q70_s3, q110_s3, q360_s3;
	logic [15:0]    base_s3;
	logic [7:0]     rv_s3, sv_s3;
	logic [IDX_W:0] lit_s3;
	logic [52:0]    qp70, qp110, qp360;
	logic [7:0]     lit_full;

	always_comb begin
		qp70     = 53'(x70_s2) * 53'(Q70_MAG);
		qp110    = 53'(x110_s2) * 53'(Q110_MAG);
		qp360    = 53'(x360_s2) * 53'(Q360_MAG);
		lit_full = div255(plit_s2);
	end

	always_ff @(posedge clk) begin
		if (ld_s3) begin
			mode_s3 <= mode_s2;
			x70_s3  <= x70_s2;
			x110_s3 <= x110_s2;
			x360_s3 <= x360_s2;
			q70_s3  <= qp70[QSH+15:QSH];
			q110_s3 <= qp110[QSH+15:QSH];
			q360_s3 <= qp360[QSH+15:QSH];
			base_s3 <= base_s2;
			rv_s3   <= div255(p160_s2);
			sv_s3   <= div255(p155_s2);
			lit_s3  <= lit_full[IDX_W:0];
		end
	end

	// Stage 4: remainders.
	mode_t          mode_s4;
	logic [12:0]    r70_s4, r110_s4, r360_s4;
	logic [15:0]    base_s4;
	logic [7:0]     rv_s4, sv_s4;
	logic [IDX_W:0] lit_s4;
	logic [28:0]    qm70, qm110, qm360;

	always_comb begin
		qm70  = 29'(q70_s3) * 29'(M70);
		qm110 = 29'(q110_s3) * 29'(M110);
		qm360 = 29'(q360_s3) * 29'(M360);
	end

	always_ff @(posedge clk) begin
		if (ld_s4) begin
			mode_s4 <= mode_s3;
			r70_s4  <= 13'(29'(x70_s3) - qm70);
			r110_s4 <= 13'(29'(x110_s3) - qm110);
			r360_s4 <= 13'(29'(x360_s3) - qm360);
			base_s4 <= base_s3;
			rv_s4   <= rv_s3;
			sv_s4   <= sv_s3;
			lit_s4  <= lit_s3;
		end
	end

	// Stage 5: comet head position and blink phase.
	frame_t      frame_s5;
	logic [27:0] hp70, hp110;
	frame_t      frame_nx;

	always_comb begin
		hp70            = 28'(r70_s4) * 28'(THINK_MAG);
		hp110           = 28'(r110_s4) * 28'(FOLLOW_MAG);
		frame_nx.mode   = mode_s4;
		frame_nx.head   = (mode_s4 == MODE_FOLLOW) ? hp110[HEAD_SH+IDX_W-1:HEAD_SH]
			: hp70[HEAD_SH+IDX_W-1:HEAD_SH];
		frame_nx.base   = base_s4;
		frame_nx.rv     = rv_s4;
		frame_nx.lit    = lit_s4;
		frame_nx.sv     = sv_s4;
		frame_nx.err_on = r360_s4 < 13'(BLINK_MS);
	end

	always_ff @(posedge clk) begin
		if (ld_s5) frame_s5 <= frame_nx;
	end

	// Frame register; the counter walks the LEDs.
	frame_t   fr_q;
	pix_req_t pix_req;

	always_ff @(posedge clk) begin
		if (fr_ld) fr_q <= frame_s5;
	end

	assign pix_req.frame = fr_q;
	assign pix_req.idx   = cnt_q;
	assign pix_req.last  = cnt_last;

	lrpg_pixel_pipe #(
		.RING_LEDS (RING_LEDS)
	) u_pixel (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (fr_vld_q),
		.in_ready  (pix_ready),
		.in_req    (pix_req),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_word  (out_word)
	);

endmodule
`default_nettype wire

// File: src/lrpg_pixel_pipe.sv
`default_nettype none
module lrpg_pixel_pipe
	import lrpg_pkg::*;
#(
	parameter int unsigned RING_LEDS = 12
) (
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire logic      in_valid,
	output logic           in_ready,
	input  wire pix_req_t  in_req,
	output logic           out_valid,
	input  wire logic      out_ready,
	output out_word_t      out_word
);

	localparam logic [IDX_W:0]   RING_N  = (IDX_W+1)'(RING_LEDS);
	localparam logic [IDX_W-1:0] HALF_D  = IDX_W'(RING_LEDS - RING_LEDS / 2);
	localparam int unsigned      HUE_SH  = 28;
	localparam logic [27:0]      HUE_MAG =
		28'(((64'd1 << HUE_SH) + 64'(RING_LEDS) - 64'd1) / 64'(RING_LEDS));
	localparam int unsigned      LIS_SH  = 20;
	localparam logic [27:0]      LIS_K   =
		28'(64'(LISTEN_FULL) * (((64'd1 << LIS_SH) + 64'(RING_LEDS) - 64'd2)
		/ 64'(RING_LEDS - 1)));

	function automatic rgb_t think_color(input logic [IDX_W-1:0] d);
		rgb_t c;
		unique case (d)
			IDX_W'(0): c = '{r: 8'd75, g: 8'd45, b: 8'd150};
			IDX_W'(1): c = '{r: 8'd54, g: 8'd32, b: 8'd108};
			IDX_W'(2): c = '{r: 8'd33, g: 8'd19, b: 8'd66};
			IDX_W'(3): c = '{r: 8'd12, g: 8'd7,  b: 8'd24};
			default:   c = RGB_OFF;
		endcase
		return c;
	endfunction

	function automatic rgb_t update_color(input logic [IDX_W-1:0] d);
		rgb_t c;
		unique case (d)
			IDX_W'(0): c = '{r: 8'd0, g: 8'd160, b: 8'd24};
			IDX_W'(1): c = '{r: 8'd0, g: 8'd118, b: 8'd17};
			IDX_W'(2): c = '{r: 8'd0, g: 8'd76,  b: 8'd11};
			IDX_W'(3): c = '{r: 8'd0, g: 8'd34,  b: 8'd5};
			default:   c = RGB_OFF;
		endcase
		return c;
	endfunction

	// Six-sector hue to color at full saturation and full value.
	function automatic rgb_t hue_color(input logic [10:0] h);
		rgb_t c;
		c = RGB_OFF;
		priority if (h < 11'd255) begin
			c.r = 8'd255;
			c.g = h[7:0];
		end else if (h < 11'd510) begin
			c.r = 8'(11'd510 - h);
			c.g = 8'd255;
		end else if (h < 11'd765) begin
			c.g = 8'd255;
			c.b = 8'(h - 11'd510);
		end else if (h < 11'd1020) begin
			c.g = 8'(11'd1020 - h);
			c.b = 8'd255;
		end else if (h < 11'd1275) begin
			c.r = 8'(h - 11'd1020);
			c.b = 8'd255;
		end else if (h < 11'd1530) begin
			c.r = 8'd255;
			c.b = 8'(11'd1530 - h);
		end else begin
			c.r = 8'd255;
		end
		return c;
	endfunction

	logic ld_p1, ld_p2, ld_p3, ld_p4, ld_p5;
	logic vld_p1, vld_p2, vld_p3, vld_p4, vld_p5;

	assign ld_p5    = !vld_p5 || out_ready;
	assign ld_p4    = !vld_p4 || ld_p5;
	assign ld_p3    = !vld_p3 || ld_p4;
	assign ld_p2    = !vld_p2 || ld_p3;
	assign ld_p1    = !vld_p1 || ld_p2;
	assign in_ready = ld_p1;
	assign out_valid = vld_p5;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_p1 <= 1'b0;
			vld_p2 <= 1'b0;
			vld_p3 <= 1'b0;
			vld_p4 <= 1'b0;
			vld_p5 <= 1'b0;
		end else begin
			if (ld_p1) vld_p1 <= in_valid;
			if (ld_p2) vld_p2 <= vld_p1;
			if (ld_p3) vld_p3 <= vld_p2;
			if (ld_p4) vld_p4 <= vld_p3;
			if (ld_p5) vld_p5 <= vld_p4;
		end
	end

	// Stage 1: registered request.
	pix_req_t req_p1;

	always_ff @(posedge clk) begin
		if (ld_p1) req_p1 <= in_req;
	end

	// Stage 2: per-pixel hue offset, comet distance and level bar color.
	pix_req_t         req_p2;
	logic [15:0]      hue_add_p2;
	logic [IDX_W-1:0] d_p2;
	logic [7:0]       lr_p2;
	logic             lit_on_p2;
	logic [33:0]      hue_prod;
	logic [33:0]      lis_prod;
	logic [IDX_W:0]   d_sum;
	logic [IDX_W:0]   d_red;

	always_comb begin
		hue_prod = 34'(req_p1.idx) * 34'(HUE_MAG);
		lis_prod = 34'(req_p1.idx) * 34'(LIS_K);
		d_sum    = (IDX_W+1)'(req_p1.frame.head) + RING_N - (IDX_W+1)'(req_p1.idx);
		d_red    = (d_sum >= RING_N) ? d_sum - RING_N : d_sum;
	end

	always_ff @(posedge clk) begin
		if (ld_p2) begin
			req_p2     <= req_p1;
			hue_add_p2 <= hue_prod[HUE_SH-1:HUE_SH-16];
			lr_p2      <= lis_prod[LIS_SH+7:LIS_SH];
			d_p2       <= d_red[IDX_W-1:0];
			lit_on_p2  <= (IDX_W+1)'(req_p1.idx) < req_p1.frame.lit;
		end
	end

	// Stage 3: hue to sector position, flat color of the other modes.
	pix_req_t    req_p3;
	logic [10:0] h6_p3;
	rgb_t        flat_p3;
	logic [15:0] hue;
	logic [26:0] h6_prod;
	rgb_t        flat;

	always_comb begin
		hue     = req_p2.frame.base + hue_add_p2;
		h6_prod = 27'(hue) * 27'd1530 + 27'd32768;
		unique case (req_p2.frame.mode)
			MODE_DARK, MODE_RAINBOW: flat = RGB_OFF;
			MODE_LISTEN: flat = lit_on_p2
				? rgb_t'{r: lr_p2, g: LISTEN_FULL - lr_p2, b: 8'd0} : RGB_OFF;
			MODE_THINK:  flat = think_color(d_p2);
			MODE_UPDATE: flat = update_color(d_p2);
			MODE_SPEAK:  flat = '{r: 8'd0, g: req_p2.frame.sv, b: req_p2.frame.sv};
			MODE_ERROR:  flat = req_p2.frame.err_on ? RGB_ERROR : RGB_OFF;
			MODE_FOLLOW: flat = (d_p2 == '0 || d_p2 == HALF_D) ? RGB_DOT : RGB_DOT_BG;
		endcase
	end

	always_ff @(posedge clk) begin
		if (ld_p3) begin
			req_p3  <= req_p2;
			h6_p3   <= h6_prod[26:16];
			flat_p3 <= flat;
		end
	end

	// Stage 4: sector decode.
	pix_req_t req_p4;
	rgb_t     hc_p4;
	rgb_t     flat_p4;

	always_ff @(posedge clk) begin
		if (ld_p4) begin
			req_p4  <= req_p3;
			hc_p4   <= hue_color(h6_p3);
			flat_p4 <= flat_p3;
		end
	end

	// Stage 5: value scaling and output register.
	logic [8:0]  vs;
	logic [16:0] pr, pg, pb;
	rgb_t        col;

	always_comb begin
		vs = 9'(req_p4.frame.rv) + 9'd1;
		pr = 17'(hc_p4.r) * 17'(vs);
		pg = 17'(hc_p4.g) * 17'(vs);
		pb = 17'(hc_p4.b) * 17'(vs);
		if (req_p4.frame.mode == MODE_RAINBOW) begin
			col = '{r: pr[15:8], g: pg[15:8], b: pb[15:8]};
		end else begin
			col = flat_p4;
		end
	end

	always_ff @(posedge clk) begin
		if (ld_p5) begin
			out_word.pixel_index <= req_p4.idx;
			out_word.red         <= col.r;
			out_word.green       <= col.g;
			out_word.blue        <= col.b;
			out_word.last        <= req_p4.last;
		end
	end

endmodule
`default_nettype wire

// File: bench/led_ring_pattern_generator_tb.sv
`timescale 1ns / 1ps
module led_ring_pattern_generator_tb;
	import lrpg_pkg::*;

	localparam int unsigned RING_LEDS = 12;
	localparam int unsigned CYCLE_LIMIT = 400000;
	localparam int unsigned RANDOM_PHASES = 6;
	localparam int unsigned FRAMES_PER_PHASE = 68;

	logic      clk = 1'b0;
	logic      arst_n = 1'b0;
	logic      cfg_we = 1'b0;
	logic      cfg_wdata = 1'b0;
	logic      in_valid = 1'b0;
	logic      in_ready;
	in_word_t  in_word = '0;
	logic      out_valid;
	logic      out_ready = 1'b0;
	out_word_t out_word;

	in_word_t    frame_requests[$];
	out_word_t   expected_pixels[$];
	int unsigned requests_left = 0;
	int unsigned mismatches = 0;
	int unsigned cycle_count = 0;
	bit          idle_rainbow = 1'b0;
	bit          in_fire = 1'b0;
	bit          out_fire = 1'b0;
	bit          in_idle_on = 1'b1;
	bit          out_idle_on = 1'b1;
	int unsigned in_gap = 0;
	int unsigned out_gap = 0;

	led_ring_pattern_generator #(
		.RING_LEDS(RING_LEDS)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_wdata(cfg_wdata),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.in_word(in_word),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_word(out_word)
	);

	always #5 clk = ~clk;

	function automatic out_word_t ring_pixel(in_word_t req, bit rainbow_in_idle,
		int unsigned idx);
		logic [31:0] t;
		logic [31:0] spin;
		int unsigned lvl, n, v, head, ring_d, drop, peak, lit, hue, h6;
		int unsigned cr, cg, cb, r, g, b;
		out_word_t   px;
		t = req.time_ms;
		lvl = req.level;
		n = RING_LEDS;
		r = 0;
		g = 0;
		b = 0;
		case (req.operation)
			OP_IDLE, OP_MUSIC: begin
				if (req.operation == OP_MUSIC || rainbow_in_idle) begin
					v = lvl * 160 / 255;
					spin = t * (32'd6 + 32'(lvl / 8));
					hue = (32'(spin[15:0]) + idx * 65536 / n) & 32'hFFFF;
					h6 = (hue * 1530 + 32768) / 65536;
					if (h6 < 510) begin
						cb = 0;
						if (h6 < 255) begin
							cr = 255;
							cg = h6;
						end else begin
							cr = 510 - h6;
							cg = 255;
						end
					end else if (h6 < 1020) begin
						cr = 0;
						if (h6 < 765) begin
							cg = 255;
							cb = h6 - 510;
						end else begin
							cg = 1020 - h6;
							cb = 255;
						end
					end else if (h6 < 1530) begin
						cg = 0;
						if (h6 < 1275) begin
							cr = h6 - 1020;
							cb = 255;
						end else begin
							cr = 255;
							cb = 1530 - h6;
						end
					end else begin
						cr = 255;
						cg = 0;
						cb = 0;
					end
					r = (cr * (v + 1)) >> 8;
					g = (cg * (v + 1)) >> 8;
					b = (cb * (v + 1)) >> 8;
				end
			end
			OP_LISTEN: begin
				lit = (lvl * n + 127) / 255;
				if (idx < lit) begin
					r = idx * 170 / (n - 1);
					g = 170 - r;
				end
			end
			OP_THINK, OP_UPDATE: begin
				head = (t / 70) % n;
				ring_d = (head + n - idx) % n;
				drop = ring_d * 42;
				peak = (req.operation == OP_THINK) ? 150 : 160;
				v = (drop >= peak) ? 0 : peak - drop;
				if (req.operation == OP_THINK) begin
					r = v / 2;
					g = v * 3 / 10;
					b = v;
				end else begin
					g = v;
					b = v * 15 / 100;
				end
			end
			OP_SPEAK: begin
				v = lvl * 155 / 255;
				g = v;
				b = v;
			end
			OP_ERROR: begin
				if (((t / 180) & 1) == 0) begin
					r = 130;
				end
			end
			OP_FOLLOWUP: begin
				head = (t / 110) % n;
				if (idx == head || idx == (head + n / 2) % n) begin
					r = 150;
					g = 68;
				end else begin
					r = 14;
					g = 6;
				end
			end
		endcase
		px.pixel_index = 6'(idx);
		px.red = 8'(r);
		px.green = 8'(g);
		px.blue = 8'(b);
		px.last = (idx == n - 1);
		return px;
	endfunction

	function automatic int unsigned draw_wait(bit idling);
		return idling ? $urandom_range(0, 14) : 0;
	endfunction

	always @(posedge clk) begin
		out_word_t want;
		cycle_count++;
		in_fire = arst_n && in_valid && in_ready;
		out_fire = arst_n && out_valid && out_ready;
		if (in_fire) begin
			for (int unsigned i = 0; i < RING_LEDS; i++)
				expected_pixels.push_back(ring_pixel(in_word, idle_rainbow, i));
			requests_left--;
		end
		if (out_fire) begin
			if (expected_pixels.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected pixel word: idx %0d rgb %0d %0d %0d last %0b",
						out_word.pixel_index, out_word.red, out_word.green,
						out_word.blue, out_word.last);
			end else begin
				want = expected_pixels.pop_front();
				if (out_word.pixel_index !== want.pixel_index || out_word.red !== want.red
					|| out_word.green !== want.green || out_word.blue !== want.blue
					|| out_word.last !== want.last) begin
					mismatches++;
					if (mismatches <= 10)
						$display("pixel mismatch: expected idx %0d rgb %0d %0d %0d last %0b, got idx %0d rgb %0d %0d %0d last %0b",
							want.pixel_index, want.red, want.green, want.blue, want.last,
							out_word.pixel_index, out_word.red, out_word.green,
							out_word.blue, out_word.last);
				end
			end
		end
	end

	always @(negedge clk) begin
		if (!in_valid || in_fire) begin
			if (in_gap != 0) begin
				in_valid <= 1'b0;
				in_gap--;
			end else if (frame_requests.size() != 0) begin
				in_word <= frame_requests.pop_front();
				in_valid <= 1'b1;
				in_gap = draw_wait(in_idle_on);
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	always @(negedge clk) begin
		if (out_fire)
			out_gap = draw_wait(out_idle_on);
		if (out_gap != 0) begin
			out_ready <= 1'b0;
			out_gap--;
		end else begin
			out_ready <= 1'b1;
		end
	end

	task automatic queue_request(logic [31:0] t, logic [2:0] op, logic [7:0] lvl);
		in_word_t req;
		req.time_ms = t;
		req.operation = op;
		req.level = lvl;
		requests_left++;
		frame_requests.push_back(req);
	endtask

	task automatic queue_random_request();
		logic [31:0] t;
		logic [7:0]  lvl;
		case ($urandom_range(0, 3))
			0: t = $urandom_range(0, 5000);
			1: t = 32'hFFFF_FFFF - $urandom_range(0, 5000);
			default: t = $urandom;
		endcase
		case ($urandom_range(0, 5))
			0: lvl = 8'd0;
			1: lvl = 8'd255;
			default: lvl = 8'($urandom_range(0, 255));
		endcase
		queue_request(t, 3'($urandom_range(0, 7)), lvl);
	endtask

	task automatic write_idle_rainbow(bit value);
		@(negedge clk);
		cfg_wdata = value;
		cfg_we = 1'b1;
		@(negedge clk);
		cfg_we = 1'b0;
		idle_rainbow = value;
	endtask

	task automatic wait_drained();
		while (requests_left != 0 || expected_pixels.size() != 0)
			@(negedge clk);
	endtask

	initial begin
		repeat (10) @(negedge clk);
		arst_n = 1'b1;

		write_idle_rainbow(1'b0);
		for (int k = 0; k < 8; k++) begin
			queue_request(32'd0, 3'(k), 8'd0);
			queue_request(32'hFFFF_FFFF, 3'(k), 8'd255);
		end
		queue_request(32'd179, OP_ERROR, 8'd0);
		queue_request(32'd180, OP_ERROR, 8'd0);
		queue_request(32'd69, OP_THINK, 8'd90);
		queue_request(32'd770, OP_UPDATE, 8'd3);
		queue_request(32'd1210, OP_FOLLOWUP, 8'd60);
		queue_request(32'd0, OP_LISTEN, 8'd10);
		queue_request(32'd0, OP_LISTEN, 8'd128);
		wait_drained();

		write_idle_rainbow(1'b1);
		queue_request(32'd0, OP_IDLE, 8'd0);
		queue_request(32'hFFFF_FFFF, OP_IDLE, 8'd255);
		queue_request(32'h8000_0000, OP_IDLE, 8'd128);
		wait_drained();

		for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
			write_idle_rainbow(phase[0]);
			in_idle_on = (phase % 4 == 0) || (phase % 4 == 3);
			out_idle_on = (phase % 4 == 0) || (phase % 4 == 2);
			repeat (FRAMES_PER_PHASE) queue_random_request();
			wait_drained();
		end

		repeat (40) @(negedge clk);
		if (mismatches == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

	initial begin
		wait (cycle_count >= CYCLE_LIMIT);
		$display("RESULT: ERROR");
		$finish;
	end

endmodule
